// File: hdl/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the Targa run-length pixel decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

    // Configuration register indexes.
    localparam logic [2:0] C_REG_WIDTH     = 3'd0;
    localparam logic [2:0] C_REG_HEIGHT    = 3'd1;
    localparam logic [2:0] C_REG_ALPHA     = 3'd2;
    localparam logic [2:0] C_REG_RLC       = 3'd3;
    localparam logic [2:0] C_REG_BOTTOM_UP = 3'd4;

    // Image size limits.
    localparam logic [12:0] C_MAX_DIM   = 13'd4096;
    localparam logic [12:0] C_MIN_WIDTH = 13'd16;
    localparam logic [12:0] C_MIN_HEIGHT = 13'd1;

    // Alpha used for 24-bit pixels.
    localparam logic [7:0] C_OPAQUE = 8'hFF;

    // Packet header fields.
    localparam int C_HDR_RUN_BIT = 7;

    // Pixel job handed from the byte decoder to the span splitter.
    typedef struct packed {
        logic        valid;
        logic [7:0]  count;
        logic [31:0] argb;
    } t_job;

    // One span toward the output register.
    typedef struct packed {
        logic        valid;
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  len;
        logic [31:0] argb;
        logic        done;
    } t_span;

endpackage

// File: hdl/targa_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// targa_rle_pixel_decoder_top
// Targa pixel-data decoder: bytes in, ARGB spans (row, column, length) out.
// ----------------------------------------------------------------------------
// The block takes one pixel-data byte per cycle into an input register while
// the input is not held, and delivers spans one per cycle through a registered
// output while the output is not stalled; a byte and its first span pass the
// input register and then the output register. A run packet whose pixels
// cross row ends is split by the span splitter into one span per row piece,
// at one span per cycle, so such a byte holds back the byte behind it in the
// input register until its remaining pieces are sent. Output stalls back up
// to the input through the output register.
module targa_rle_pixel_decoder_top
    import trle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    // Byte input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] start_image
    // Span output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [11:0] row_index, [23:12] col_index,
                                          // [31:24] span_length, [63:32] argb_color
    output logic        o_m_axis_tlast    // image_done
);

    logic [12:0] r_width, r_height;
    logic        r_alpha, r_rlc, r_bottom_up;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;

    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_out_last;

    logic        s_out_free;
    logic        s_adv;
    logic        s_fin;
    t_job        s_job;
    t_span       s_span;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 13'd16;
            r_height    <= 13'd11;
            r_alpha     <= 1'b0;
            r_rlc       <= 1'b1;
            r_bottom_up <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                C_REG_WIDTH:     r_width     <= i_cfg_wdata;
                C_REG_HEIGHT:    r_height    <= i_cfg_wdata;
                C_REG_ALPHA:     r_alpha     <= i_cfg_wdata[0];
                C_REG_RLC:       r_rlc       <= i_cfg_wdata[0];
                C_REG_BOTTOM_UP: r_bottom_up <= i_cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Input register: refilled when empty or when its item moves on.
    assign o_s_axis_tready = !r_in_valid || s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser;
        end
    end

    trle_byte_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_fin       (s_fin),
        .i_adv       (s_adv),
        .i_has_alpha (r_alpha),
        .i_rlc       (r_rlc),
        .o_job       (s_job)
    );

    trle_span_split u_split (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (s_job),
        .i_in_valid  (r_in_valid),
        .i_start     (r_in_start),
        .i_out_free  (s_out_free),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_bottom_up (r_bottom_up),
        .o_fin       (s_fin),
        .o_adv       (s_adv),
        .o_span      (s_span)
    );

    // Output register: takes a span when empty or being drained.
    assign s_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_span.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_free && s_span.valid) begin
            r_out_data <= {s_span.argb, s_span.len, s_span.col, s_span.row};
            r_out_last <= s_span.done;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// File: hdl/trle_byte_decode.sv
// ----------------------------------------------------------------------------
// trle_byte_decode
// Byte-level decoder: packet headers, BGR(A) assembly and pixel job output.
// ----------------------------------------------------------------------------
module trle_byte_decode
    import trle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_fin,
    input  logic       i_adv,
    input  logic       i_has_alpha,
    input  logic       i_rlc,
    output t_job       o_job
);

    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_hold, n_hold;
    logic [7:0]  r_left, n_left;
    logic        r_is_run, n_is_run;
    logic        r_in_pkt, n_in_pkt;

    logic [1:0]  s_phase;
    logic [7:0]  s_left;
    logic        s_is_run;
    logic        s_in_pkt;
    logic        s_fin;
    logic [1:0]  s_last;
    logic [7:0]  s_alpha;

    // Start of image clears the packet state before the byte is looked at.
    always_comb begin
        s_phase  = i_start ? 2'd0 : r_phase;
        s_left   = i_start ? 8'd0 : r_left;
        s_is_run = i_start ? 1'b0 : r_is_run;
        s_in_pkt = i_start ? 1'b0 : r_in_pkt;
        s_fin    = i_start ? 1'b0 : i_fin;
        s_last   = i_has_alpha ? 2'd3 : 2'd2;
        s_alpha  = ((s_phase == 2'd3) && i_has_alpha) ? i_byte : C_OPAQUE;
    end

    // Next state and pixel job for the byte in the input register.
    always_comb begin
        n_phase  = s_phase;
        n_hold   = r_hold;
        n_left   = s_left;
        n_is_run = s_is_run;
        n_in_pkt = s_in_pkt;
        o_job    = '0;
        if (!s_fin) begin
            if (i_rlc && !s_in_pkt) begin
                n_is_run = i_byte[C_HDR_RUN_BIT];
                n_left   = {1'b0, i_byte[6:0]} + 8'd1;
                n_in_pkt = 1'b1;
                n_phase  = 2'd0;
            end else begin
                case (s_phase)
                    2'd0:    n_hold[7:0]   = i_byte;
                    2'd1:    n_hold[15:8]  = i_byte;
                    2'd2:    n_hold[23:16] = i_byte;
                    default: n_hold        = r_hold;
                endcase
                if (s_phase < s_last) begin
                    n_phase = s_phase + 2'd1;
                end else begin
                    n_phase    = 2'd0;
                    o_job.argb = {s_alpha, n_hold};
                    if (!i_rlc) begin
                        o_job.count = 8'd1;
                    end else if (s_is_run) begin
                        o_job.count = s_left;
                        n_left      = 8'd0;
                        n_in_pkt    = 1'b0;
                    end else begin
                        o_job.count = 8'd1;
                        if (s_left != 8'd0) begin
                            n_left = s_left - 8'd1;
                        end
                        if (n_left == 8'd0) begin
                            n_in_pkt = 1'b0;
                        end
                    end
                    o_job.valid = (o_job.count != 8'd0);
                end
            end
        end
    end

    // Packet state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_hold   <= '0;
            r_left   <= '0;
            r_is_run <= 1'b0;
            r_in_pkt <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_hold   <= n_hold;
            r_left   <= n_left;
            r_is_run <= n_is_run;
            r_in_pkt <= n_in_pkt;
        end
    end

endmodule

// File: hdl/trle_span_split.sv
// ----------------------------------------------------------------------------
// trle_span_split
// Tracks position and splits spans at row ends, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module trle_span_split
    import trle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_in_valid,
    input  logic        i_start,
    input  logic        i_out_free,
    input  logic [12:0] i_width,
    input  logic [12:0] i_height,
    input  logic        i_bottom_up,
    output logic        o_fin,
    output logic        o_adv,
    output t_span       o_span
);

    logic [11:0] r_col, n_col;
    logic [12:0] r_row, n_row;
    logic        r_fin, n_fin;
    logic        r_busy, n_busy;
    logic [7:0]  r_count, n_count;
    logic [31:0] r_argb, n_argb;

    logic [12:0] s_w, s_h;
    logic [11:0] s_col;
    logic [12:0] s_row;
    logic [7:0]  s_cnt;
    logic [31:0] s_argb;
    logic        s_step;
    logic        s_wrap0, s_end0, s_wrap1, s_done;
    logic [12:0] s_c0, s_r0, s_room, s_c1, s_r1, s_brow;
    logic [7:0]  s_take, s_rem;

    // Clamp the configured size to the supported range.
    always_comb begin
        s_w = i_width;
        if (s_w < C_MIN_WIDTH) s_w = C_MIN_WIDTH;
        if (s_w > C_MAX_DIM)   s_w = C_MAX_DIM;
        s_h = i_height;
        if (s_h < C_MIN_HEIGHT) s_h = C_MIN_HEIGHT;
        if (s_h > C_MAX_DIM)    s_h = C_MAX_DIM;
    end

    // Pick the source of this cycle's span: a pending remainder or a new job.
    always_comb begin
        if (r_busy) begin
            s_col  = r_col;
            s_row  = r_row;
            s_cnt  = r_count;
            s_argb = r_argb;
            s_step = i_out_free;
        end else begin
            s_col  = i_start ? 12'd0 : r_col;
            s_row  = i_start ? 13'd0 : r_row;
            s_cnt  = i_job.count;
            s_argb = i_job.argb;
            s_step = i_in_valid && i_job.valid && i_out_free;
        end
        o_adv = i_in_valid && !r_busy && (!i_job.valid || i_out_free);
    end

    // One split step: wrap, clip to the row end, advance the position.
    always_comb begin
        s_wrap0 = ({1'b0, s_col} >= s_w);
        s_c0    = s_wrap0 ? 13'd0 : {1'b0, s_col};
        s_r0    = s_wrap0 ? s_row + 13'd1 : s_row;
        s_end0  = (s_r0 >= s_h);
        s_room  = s_w - s_c0;
        s_take  = ({5'd0, s_cnt} < s_room) ? s_cnt : s_room[7:0];
        s_c1    = s_c0 + {5'd0, s_take};
        s_rem   = s_cnt - s_take;
        s_wrap1 = (s_c1 >= s_w);
        s_r1    = s_r0 + 13'd1;
        s_done  = s_wrap1 && (s_r1 >= s_h);
        s_brow  = i_bottom_up ? (s_h - 13'd1 - s_r0) : s_r0;
    end

    // Next position state and span output.
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_fin   = r_fin;
        n_busy  = r_busy;
        n_count = r_count;
        n_argb  = r_argb;
        o_span  = '0;
        if (o_adv && i_start) begin
            n_col = 12'd0;
            n_row = 13'd0;
            n_fin = 1'b0;
        end
        if (s_step) begin
            if (s_end0) begin
                n_col  = s_c0[11:0];
                n_row  = s_r0;
                n_fin  = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_col   = s_wrap1 ? 12'd0 : s_c1[11:0];
                n_row   = s_wrap1 ? s_r1 : s_r0;
                n_fin   = s_done;
                n_busy  = !s_done && (s_rem != 8'd0);
                n_count = s_rem;
                n_argb  = s_argb;
                o_span.valid = 1'b1;
                o_span.row   = s_brow[11:0];
                o_span.col   = s_c0[11:0];
                o_span.len   = s_take;
                o_span.argb  = s_argb;
                o_span.done  = s_done;
            end
        end
    end

    // Position and split registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_fin   <= 1'b0;
            r_busy  <= 1'b0;
            r_count <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_fin   <= n_fin;
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    // Color of a pending remainder.
    always_ff @(posedge i_clk) begin
        r_argb <= n_argb;
    end

    assign o_fin = r_fin;

endmodule

// File: tb/sv/targa_rle_pixel_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// targa_rle_pixel_decoder_top_tb
// Self-checking bench for the Targa pixel-data span decoder.
// ----------------------------------------------------------------------------
// Pixel-data bytes are streamed into the decoder while a span predictor in
// the bench decodes the same bytes. Every span that leaves the block is
// compared field by field against the oldest predicted span. Directed tests
// cover decoding without a start flag, the end of an image with trailing
// bytes, alpha handling, clamped and shrunken image sizes and a mode change
// in the middle of a packet. A long random part then decodes many small
// images under changing settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module targa_rle_pixel_decoder_top_tb;
    import trle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to wait after the last span before a register write.
    localparam int SETTLE_CYCLES = 4;
    // Cycles to keep watching the output once every span has arrived.
    localparam int END_CYCLES = 20;
    // The slowest correct stretch without any item moved is a receiver hold,
    // a sender gap, a settle and five register writes; this limit is many
    // times that.
    localparam int IDLE_LIMIT = 2000;
    // Random pixel-data items that the decoder actually consumes.
    localparam int RANDOM_ITEMS = 380;

    // One span as predicted.
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  len;
        logic [31:0] argb;
        logic        done;
    } t_exp_span;

    // Output stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_HOLD
    } t_rx_mode;

    // DUT ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [12:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;   // [7:0] data_byte
    logic        i_s_axis_tuser = 1'b0; // [0] start_image
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;        // [11:0] row_index, [23:12] col_index,
                                        // [31:24] span_length, [63:32] argb_color
    logic        o_m_axis_tlast;        // image_done

    // Predictor copy of the registers.
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic        cfg_alpha;
    logic        cfg_rlc;
    logic        cfg_bottom_up;

    // Predictor copy of the decoder state.
    logic [1:0]  phase_q;
    logic [23:0] color_q;
    logic [7:0]  left_q;
    logic        run_q;
    logic        in_pkt_q;
    logic [11:0] col_q;
    logic [12:0] row_q;
    logic        done_q;

    t_exp_span expected_spans[$];

    // Bench bookkeeping.
    int       fail_count = 0;
    int       spans_seen = 0;
    int       live_items = 0;
    int       phase_bytes = 0;
    int       image_phases = 0;
    int       burst_left = 0;
    bit       quiet = 1'b0;
    bit       start_pending = 1'b0;
    int       rx_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    targa_rle_pixel_decoder_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state after reset.
    function automatic void reset_model();
        cfg_width     = 13'd16;
        cfg_height    = 13'd11;
        cfg_alpha     = 1'b0;
        cfg_rlc       = 1'b1;
        cfg_bottom_up = 1'b1;
        phase_q  = '0;
        color_q  = '0;
        left_q   = '0;
        run_q    = 1'b0;
        in_pkt_q = 1'b0;
        col_q    = '0;
        row_q    = '0;
        done_q   = 1'b0;
    endfunction

    // Lay count pixels of one color from the current position, one span per
    // row piece, and queue the spans.
    function automatic void push_pixels(input int unsigned count, input logic [31:0] argb);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned take;
        int unsigned k;
        t_exp_span s;
        w = cfg_width;
        if (w < C_MIN_WIDTH) w = C_MIN_WIDTH;
        if (w > C_MAX_DIM) w = C_MAX_DIM;
        h = cfg_height;
        if (h < C_MIN_HEIGHT) h = C_MIN_HEIGHT;
        if (h > C_MAX_DIM) h = C_MAX_DIM;
        c = col_q;
        r = row_q;
        k = 0;
        while (count > 0 && !done_q && k < 9) begin
            // A column past a shrunken width wraps to the next row.
            if (c >= w) begin
                c = 0;
                r++;
            end
            // A row past the height ends the image without a span.
            if (r >= h) begin
                done_q = 1'b1;
                break;
            end
            take = w - c;
            if (take > count) take = count;
            s.row  = 12'(cfg_bottom_up ? (h - 1 - r) : r);
            s.col  = 12'(c);
            s.len  = 8'(take);
            s.argb = argb;
            s.done = 1'b0;
            c += take;
            count -= take;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) begin
                    done_q = 1'b1;
                    s.done = 1'b1;
                end
            end
            expected_spans.push_back(s);
            k++;
        end
        col_q = 12'(c);
        row_q = 13'(r);
    endfunction

    // Decode one accepted byte; returns 0 when the byte is ignored because
    // the image is complete.
    function automatic bit predict_spans(input logic [7:0] b, input logic st);
        logic [1:0]  last;
        logic [7:0]  alpha;
        logic [31:0] argb;
        int unsigned n;
        if (st) begin
            phase_q  = '0;
            in_pkt_q = 1'b0;
            left_q   = '0;
            run_q    = 1'b0;
            col_q    = '0;
            row_q    = '0;
            done_q   = 1'b0;
        end
        if (done_q) return 1'b0;

        // Packet header byte.
        if (cfg_rlc && !in_pkt_q) begin
            run_q    = b[C_HDR_RUN_BIT];
            left_q   = {1'b0, b[6:0]} + 8'd1;
            in_pkt_q = 1'b1;
            phase_q  = '0;
            return 1'b1;
        end

        // Gather B, G, R; the alpha byte is not stored.
        if (phase_q < 2'd3) color_q[phase_q * 8 +: 8] = b;
        last = cfg_alpha ? 2'd3 : 2'd2;
        if (phase_q < last) begin
            phase_q++;
            return 1'b1;
        end
        alpha = (phase_q == 2'd3 && cfg_alpha) ? b : C_OPAQUE;
        argb = {alpha, color_q};
        phase_q = '0;

        if (!cfg_rlc) begin
            push_pixels(1, argb);
        end else if (run_q) begin
            n = left_q;
            left_q = '0;
            in_pkt_q = 1'b0;
            push_pixels(n, argb);
        end else begin
            if (left_q > 0) left_q--;
            if (left_q == 0) in_pkt_q = 1'b0;
            push_pixels(1, argb);
        end
        return 1'b1;
    endfunction

    // Send one byte, opening a random gap at the end of each burst.
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = quiet ? 0 : $urandom_range(0, 5);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= st;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        phase_bytes++;
        if (predict_spans(b, st)) live_items++;
    endtask

    // Send a byte that carries the pending start flag.
    task automatic put_byte(input logic [7:0] b);
        send_byte(b, start_pending);
        start_pending = 1'b0;
    endtask

    // Send one pixel with random color bytes.
    task automatic send_pixel();
        repeat (cfg_alpha ? 4 : 3) put_byte(8'($urandom_range(0, 255)));
    endtask

    // Hold the input off until every predicted span has arrived.
    task automatic wait_spans_drained(input int extra);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // Write one register; only called while the decoder is idle.
    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            C_REG_WIDTH:     cfg_width = val;
            C_REG_HEIGHT:    cfg_height = val;
            C_REG_ALPHA:     cfg_alpha = val[0];
            C_REG_RLC:       cfg_rlc = val[0];
            C_REG_BOTTOM_UP: cfg_bottom_up = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A 128-pixel run with the reset settings and no start flag: decoding
    // begins at position zero and splits into one span per row.
    task automatic test_run_from_reset();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // A run that reaches the last pixel, then a byte past the image.
    task automatic test_image_end_trailing();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h7E, 1'b0);
    endtask

    // Plain 32-bit pixels with out-of-range sizes; alpha is switched off
    // while the alpha byte is due.
    task automatic test_plain_alpha_drop();
        wait_spans_drained(SETTLE_CYCLES);
        write_reg(C_REG_RLC, 13'd0);
        write_reg(C_REG_ALPHA, 13'd1);
        write_reg(C_REG_BOTTOM_UP, 13'd0);
        write_reg(C_REG_WIDTH, 13'd5);
        write_reg(C_REG_HEIGHT, 13'd0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
        wait_spans_drained(SETTLE_CYCLES);
        write_reg(C_REG_ALPHA, 13'd0);
        send_byte(8'hC3, 1'b0);
    endtask

    // Sizes shrink under the current position, and plain mode interrupts a
    // raw packet that run-length mode then resumes.
    task automatic test_shrink_and_mode_switch();
        wait_spans_drained(SETTLE_CYCLES);
        write_reg(C_REG_WIDTH, 13'd8191);
        write_reg(C_REG_HEIGHT, 13'd8191);
        write_reg(C_REG_RLC, 13'd1);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        wait_spans_drained(SETTLE_CYCLES);
        write_reg(C_REG_WIDTH, 13'd16);
        send_byte(8'h01, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h66, 1'b0);
        wait_spans_drained(SETTLE_CYCLES);
        write_reg(C_REG_RLC, 13'd0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h88, 1'b0);
        send_byte(8'h99, 1'b0);
        wait_spans_drained(SETTLE_CYCLES);
        write_reg(C_REG_HEIGHT, 13'd1);
        write_reg(C_REG_RLC, 13'd1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hCC, 1'b0);
        send_byte(8'hDD, 1'b0);
    endtask

    // Random images: new settings per image, mostly well-formed packets or
    // pixels with random content, some noise bytes and stray start flags.
    task automatic test_random_images();
        int          goal;
        int          target;
        int          pick;
        int          npix;
        bit          paused;
        logic [12:0] w;
        logic [12:0] h;
        logic [7:0]  hdr;
        goal = live_items + RANDOM_ITEMS;
        paused = 1'b0;
        while (live_items < goal) begin
            wait_spans_drained(SETTLE_CYCLES);
            case ($urandom_range(0, 9))
                0:       w = C_MIN_WIDTH;
                1:       w = C_MAX_DIM;
                2:       w = 13'($urandom_range(0, 15));
                3:       w = 13'($urandom_range(4097, 8191));
                default: w = 13'($urandom_range(16, 40));
            endcase
            case ($urandom_range(0, 9))
                0:       h = C_MIN_HEIGHT;
                1:       h = C_MAX_DIM;
                2:       h = 13'd0;
                3:       h = 13'($urandom_range(4097, 8191));
                default: h = 13'($urandom_range(1, 5));
            endcase
            write_reg(C_REG_WIDTH, w);
            write_reg(C_REG_HEIGHT, h);
            write_reg(C_REG_ALPHA, 13'($urandom_range(0, 1)));
            write_reg(C_REG_RLC, 13'($urandom_range(0, 3) != 0));
            write_reg(C_REG_BOTTOM_UP, 13'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 3) == 0);
            // Now and then the image simply continues under the new settings.
            start_pending = ($urandom_range(0, 5) != 0);
            target = $urandom_range(12, 60);
            phase_bytes = 0;
            while (phase_bytes < target && (start_pending || !done_q)) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_byte(8'($urandom_range(0, 255)),
                              start_pending | ($urandom_range(0, 3) == 0));
                    start_pending = 1'b0;
                end else if (pick == 1 && (!paused || $urandom_range(0, 3) == 0)) begin
                    wait_spans_drained(0);
                    paused = 1'b1;
                end else if (!cfg_rlc) begin
                    send_pixel();
                end else if ($urandom_range(0, 1)) begin
                    // Run packet, mostly short, sometimes up to 128 pixels.
                    case ($urandom_range(0, 9)) inside
                        [0:5]:   hdr = 8'($urandom_range(0, 3));
                        [6:7]:   hdr = 8'($urandom_range(4, 15));
                        default: hdr = 8'($urandom_range(16, 127));
                    endcase
                    hdr[C_HDR_RUN_BIT] = 1'b1;
                    put_byte(hdr);
                    send_pixel();
                end else begin
                    // Raw packet; a few headers promise more than follows.
                    if ($urandom_range(0, 9) == 0) begin
                        hdr = 8'($urandom_range(0, 127));
                        npix = $urandom_range(0, 2);
                    end else begin
                        npix = $urandom_range(1, 5);
                        hdr = 8'(npix - 1);
                    end
                    put_byte(hdr);
                    repeat (npix) send_pixel();
                end
            end
            image_phases++;
        end
    endtask

    // Let the last spans out and watch for anything extra.
    task automatic test_final_drain();
        wait_spans_drained(END_CYCLES);
    endtask

    // Output stalls: each stretch picks a pattern and a length.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(3, 16) : $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     i_m_axis_tready <= 1'b1;
            RX_COIN:     i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_m_axis_tready <= (rx_left % 3 != 0);
            default:     i_m_axis_tready <= (rx_left == 0);
        endcase
    end

    // Compare each span leaving the block with the oldest prediction.
    always @(posedge i_clk) begin : check_spans
        t_exp_span want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            spans_seen++;
            if (expected_spans.size() == 0) begin
                fail_count++;
                $error("span with no prediction: tdata %h, tlast %b",
                       o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = expected_spans.pop_front();
                if (o_m_axis_tdata[11:0] !== want.row) begin
                    fail_count++;
                    $error("row_index: expected %0d, actual %0d",
                           want.row, o_m_axis_tdata[11:0]);
                end
                if (o_m_axis_tdata[23:12] !== want.col) begin
                    fail_count++;
                    $error("col_index: expected %0d, actual %0d",
                           want.col, o_m_axis_tdata[23:12]);
                end
                if (o_m_axis_tdata[31:24] !== want.len) begin
                    fail_count++;
                    $error("span_length: expected %0d, actual %0d",
                           want.len, o_m_axis_tdata[31:24]);
                end
                if (o_m_axis_tdata[63:32] !== want.argb) begin
                    fail_count++;
                    $error("argb_color: expected %h, actual %h",
                           want.argb, o_m_axis_tdata[63:32]);
                end
                if (o_m_axis_tlast !== want.done) begin
                    fail_count++;
                    $error("image_done: expected %b, actual %b",
                           want.done, o_m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid === 1'b1 && i_m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $error("no item moved for %0d cycles, %0d spans still predicted",
               IDLE_LIMIT, expected_spans.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_run_from_reset();
        test_image_end_trailing();
        test_plain_alpha_drop();
        test_shrink_and_mode_switch();
        test_random_images();
        test_final_drain();
        $display("Decoded %0d pixel-data items in %0d random image phases; %0d spans compared.",
                 live_items, image_phases, spans_seen);
        $display("Covered plain and run-length data, 24/32-bit pixels, both row orders.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/trle_pkg.sv
hdl/trle_byte_decode.sv
hdl/trle_span_split.sv
hdl/targa_rle_pixel_decoder_top.sv
tb/sv/targa_rle_pixel_decoder_top_tb.sv
